[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define TTS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// implication checked at the same edge
`define TTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[hdl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// shared types, constants and width helpers of the trilinear texel sampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tts_pkg;

  localparam int TTS_GRID_SIZE   = 32;
  localparam int TTS_FRAC_BITS   = 8;
  localparam int TTS_TEXEL_BITS  = 16;
  localparam int TTS_QUEUE_DEPTH = 4;

  localparam int COORD_W = 13;
  localparam int WIDX_W  = 5;
  localparam int FIELD_W = 16;
  localparam int OUT_W   = 16;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } tts_cmd_t;

  typedef struct packed {
    tts_cmd_t           command;
    logic [WIDX_W-1:0]  write_x;
    logic [WIDX_W-1:0]  write_y;
    logic [WIDX_W-1:0]  write_z;
    logic [FIELD_W-1:0] texel_red;
    logic [FIELD_W-1:0] texel_green;
    logic [FIELD_W-1:0] texel_blue;
    logic [COORD_W-1:0] sample_x;
    logic [COORD_W-1:0] sample_y;
    logic [COORD_W-1:0] sample_z;
  } tts_request_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_red;
    logic [OUT_W-1:0] out_green;
    logic [OUT_W-1:0] out_blue;
  } tts_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tts_qstat_t;

  // bits of a per-bank index along one axis
  function automatic int tts_half_w(int grid);
    int h;
    h = $clog2((grid + 1) >> 1);
    return (h < 1) ? 1 : h;
  endfunction

  // one axis in a queue entry: two bank indexes, two weights, two masks
  function automatic int tts_axis_w(int grid, int frac);
    return 2 * tts_half_w(grid) + 2 * (frac + 1) + 2;
  endfunction

  function automatic int tts_entry_w(int grid, int frac, int texel);
    return 1 + 3 * texel + 3 * tts_axis_w(grid, frac);
  endfunction

endpackage

[hdl/tts_front.sv]
// ----------------------------------------------------------------------------
// tts_front
// classifies requests, splits sample coordinates into bank indexes and
// weights, drops writes outside the grid and queues the rest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tts_front import tts_pkg::*; #(
  parameter int GRID_SIZE  = TTS_GRID_SIZE,
  parameter int FRAC_BITS  = TTS_FRAC_BITS,
  parameter int TEXEL_BITS = TTS_TEXEL_BITS
) (
  input  logic                   start,
  input  tts_request_t           request,
  input  tts_qstat_t             qstat,
  output logic                   push,
  output logic [tts_entry_w(GRID_SIZE, FRAC_BITS, TEXEL_BITS)-1:0] entry
);

  localparam int IDXW = $clog2(GRID_SIZE);
  localparam int HW   = tts_half_w(GRID_SIZE);
  localparam int WW   = FRAC_BITS + 1;
  localparam int AXW  = tts_axis_w(GRID_SIZE, FRAC_BITS);
  localparam logic [31:0]   TOP = 32'((GRID_SIZE - 1) << FRAC_BITS);
  localparam logic [WW-1:0] ONE = WW'(1 << FRAC_BITS);

  logic [COORD_W-1:0]      scoord [3];
  logic [WIDX_W-1:0]       wcoord [3];
  logic [AXW-1:0]          axf [3];
  logic [2:0]              in_grid;
  logic                    is_sample;
  logic [31:0]             r32, g32, b32;
  logic [3*TEXEL_BITS-1:0] tex;

  assign scoord[0] = request.sample_x;
  assign scoord[1] = request.sample_y;
  assign scoord[2] = request.sample_z;
  assign wcoord[0] = request.write_x;
  assign wcoord[1] = request.write_y;
  assign wcoord[2] = request.write_z;

  assign is_sample = (request.command == CMD_SAMPLE);

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [31:0]          cc, cl, lo32, hi32, wc32;
    logic [IDXW-1:0]      lo, hi;
    logic [FRAC_BITS-1:0] f;
    logic                 par, span;
    logic [HW-1:0]        lo_h, hi_h, wh, a0, a1;
    logic [WW-1:0]        wlo, whi, w0, w1;
    logic                 m0, m1;

    always_comb begin
      cc   = 32'(scoord[k]);
      cl   = (cc > TOP) ? TOP : cc;
      lo   = cl[FRAC_BITS +: IDXW];
      f    = cl[FRAC_BITS-1:0];
      lo32 = 32'(lo);
      hi32 = (lo32 + 32'd1 < 32'(GRID_SIZE)) ? lo32 + 32'd1 : 32'(GRID_SIZE - 1);
      hi   = hi32[IDXW-1:0];
      par  = lo[0];
      span = (hi != lo);
      lo_h = HW'(lo32 >> 1);
      hi_h = HW'(hi32 >> 1);
      wlo  = ONE - WW'(f);
      whi  = WW'(f);
      wc32 = 32'(wcoord[k]);
      wh   = HW'(wc32 >> 1);
      if (is_sample) begin
        a0 = par ? hi_h : lo_h;
        a1 = par ? lo_h : hi_h;
        w0 = par ? whi : wlo;
        w1 = par ? wlo : whi;
        m0 = !par || span;
        m1 = par || span;
      end else begin
        a0 = wh;
        a1 = wh;
        w0 = '0;
        w1 = '0;
        m0 = !wcoord[k][0];
        m1 = wcoord[k][0];
      end
    end

    assign axf[k]     = {m1, m0, w1, w0, a1, a0};
    assign in_grid[k] = (wc32 < 32'(GRID_SIZE));
  end

  assign r32 = 32'(request.texel_red);
  assign g32 = 32'(request.texel_green);
  assign b32 = 32'(request.texel_blue);
  assign tex = {r32[TEXEL_BITS-1:0], g32[TEXEL_BITS-1:0], b32[TEXEL_BITS-1:0]};

  assign push  = start && !qstat.full && (is_sample || (&in_grid));
  assign entry = {is_sample, tex, axf[2], axf[1], axf[0]};

endmodule

[hdl/tts_queue.sv]
// ----------------------------------------------------------------------------
// tts_queue
// short first-in first-out buffer between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tts_queue import tts_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = TTS_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output tts_qstat_t       stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  `TTS_ASSERT(a_no_underflow, clk, rst, !(pop && stat.empty))
  `TTS_ASSERT_IMPL(a_no_overflow, clk, rst, push && !pop, count < CW'(DEPTH))
  `TTS_ASSERT_IMPL(a_empty_ptrs, clk, rst, stat.empty, wr_ptr == rd_ptr)

endmodule

[hdl/tts_back.sv]
// ----------------------------------------------------------------------------
// tts_back
// eight parity banks of texels, weight products, corner products and an
// adder tree producing one interpolated rgb result per sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tts_back import tts_pkg::*; #(
  parameter int GRID_SIZE  = TTS_GRID_SIZE,
  parameter int FRAC_BITS  = TTS_FRAC_BITS,
  parameter int TEXEL_BITS = TTS_TEXEL_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  tts_qstat_t  qstat,
  input  logic [tts_entry_w(GRID_SIZE, FRAC_BITS, TEXEL_BITS)-1:0] head,
  output logic        pop,
  output logic        done,
  output tts_result_t result
);

  localparam int EW   = tts_entry_w(GRID_SIZE, FRAC_BITS, TEXEL_BITS);
  localparam int HW   = tts_half_w(GRID_SIZE);
  localparam int WW   = FRAC_BITS + 1;
  localparam int AXW  = tts_axis_w(GRID_SIZE, FRAC_BITS);
  localparam int T    = TEXEL_BITS;
  localparam int PRW  = 3 * WW + T;
  localparam int SW   = 3 * FRAC_BITS + TEXEL_BITS + 16;
  localparam int BANK_DEPTH = 2 ** (3 * HW);

  logic [HW-1:0]    ad [3][2];
  logic [WW-1:0]    wt [3][2];
  logic             mk [3][2];
  logic [3*T-1:0]   tex;
  logic             is_sample, pop_sample;
  logic [7:0]       we, bank_mask;

  logic [3*T-1:0]   rd [8];
  logic [2*WW-1:0]  w_yz1 [8];
  logic [WW-1:0]    wx1 [8];
  logic [7:0]       mask1;
  logic [3*WW-1:0]  w2 [8];
  logic [3*T-1:0]   d2 [8];
  logic [PRW-1:0]   term3 [8][3];
  logic [SW-1:0]    s4 [4][3];
  logic [SW-1:0]    s5 [2][3];
  logic [SW-1:0]    fin [3];
  logic [OUT_W-1:0] out_ch [3];
  logic             v1, v2, v3, v4, v5;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    for (genvar p = 0; p < 2; p++) begin : g_par
      assign ad[k][p] = head[k*AXW + p*HW +: HW];
      assign wt[k][p] = head[k*AXW + 2*HW + p*WW +: WW];
      assign mk[k][p] = head[k*AXW + 2*HW + 2*WW + p];
    end
  end

  assign tex        = head[3*AXW +: 3*T];
  assign is_sample  = (tts_cmd_t'(head[EW-1]) == CMD_SAMPLE);
  assign pop        = !qstat.empty;
  assign pop_sample = pop && is_sample;

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam int BX = b & 1;
    localparam int BY = (b >> 1) & 1;
    localparam int BZ = (b >> 2) & 1;

    logic [3*HW-1:0] addr;
    logic [3*T-1:0]  mem [BANK_DEPTH];

    assign addr         = {ad[2][BZ], ad[1][BY], ad[0][BX]};
    assign bank_mask[b] = mk[2][BZ] & mk[1][BY] & mk[0][BX];
    assign we[b]        = pop && !is_sample && bank_mask[b];

    always_ff @(posedge clk) begin
      if (we[b]) begin
        mem[addr] <= tex;
      end
      rd[b] <= mem[addr];
    end

    always_ff @(posedge clk) begin
      w_yz1[b] <= (2*WW)'(wt[2][BZ]) * (2*WW)'(wt[1][BY]);
      wx1[b]   <= wt[0][BX];
      mask1[b] <= bank_mask[b];
      w2[b]    <= (3*WW)'(w_yz1[b]) * (3*WW)'(wx1[b]);
      d2[b]    <= mask1[b] ? rd[b] : '0;
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
      always_ff @(posedge clk) begin
        term3[b][c] <= PRW'(w2[b]) * PRW'(d2[b][c*T +: T]);
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_tree
    for (genvar j = 0; j < 4; j++) begin : g_l1
      always_ff @(posedge clk) begin
        s4[j][c] <= SW'(term3[2*j][c]) + SW'(term3[2*j+1][c]);
      end
    end
    for (genvar j = 0; j < 2; j++) begin : g_l2
      always_ff @(posedge clk) begin
        s5[j][c] <= s4[2*j][c] + s4[2*j+1][c];
      end
    end
    assign fin[c]    = s5[0][c] + s5[1][c];
    assign out_ch[c] = fin[c][3*FRAC_BITS +: OUT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= pop_sample;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    result.out_blue  <= out_ch[0];
    result.out_green <= out_ch[1];
    result.out_red   <= out_ch[2];
  end

  `TTS_ASSERT_IMPL(a_done_src, clk, rst, done, $past(pop_sample, 6))
  `TTS_ASSERT_IMPL(a_one_bank, clk, rst, pop && !is_sample, $onehot(we))

endmodule

[hdl/trilinear_texel_sampler_top.sv]
// ----------------------------------------------------------------------------
// trilinear_texel_sampler_top
// texel store loaded by write requests and sampled with trilinear blending
// ----------------------------------------------------------------------------
//   channel   handshake       payload
//   request   start / busy    request (tts_request_t)
//   result    done strobe     result  (tts_result_t)
//
//   one request per cycle unless busy; eight parity banks give all eight corners
//   at once; a sample's strobe follows the queue, bank read, products, adder tree
//   busy rises only when the request queue is full
//   the result strobe cannot be held off; it lasts one cycle
//   reset clears the queue and the pipeline valids, not the texel banks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trilinear_texel_sampler_top import tts_pkg::*; #(
  parameter int GRID_SIZE   = TTS_GRID_SIZE,
  parameter int FRAC_BITS   = TTS_FRAC_BITS,
  parameter int TEXEL_BITS  = TTS_TEXEL_BITS,
  parameter int QUEUE_DEPTH = TTS_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  tts_request_t request,
  output logic         done,
  output tts_result_t  result
);

  localparam int EW = tts_entry_w(GRID_SIZE, FRAC_BITS, TEXEL_BITS);

  tts_qstat_t    qstat;
  logic          push, pop;
  logic [EW-1:0] entry, head;

  assign busy = qstat.full;

  tts_front #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS),
    .TEXEL_BITS(TEXEL_BITS)
  ) u_front (
    .start  (start),
    .request(request),
    .qstat  (qstat),
    .push   (push),
    .entry  (entry)
  );

  tts_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .din (entry),
    .pop (pop),
    .head(head),
    .stat(qstat)
  );

  tts_back #(
    .GRID_SIZE (GRID_SIZE),
    .FRAC_BITS (FRAC_BITS),
    .TEXEL_BITS(TEXEL_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .qstat (qstat),
    .head  (head),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the trilinear texel sampler: writes texels and
// samples them, predicts every blended color and checks each result strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tts_pkg::*;

  localparam int GRID_CELLS   = TTS_GRID_SIZE * TTS_GRID_SIZE * TTS_GRID_SIZE;
  localparam int FRAC_ONE     = 1 << TTS_FRAC_BITS;
  localparam int GRID_TOP     = (TTS_GRID_SIZE - 1) << TTS_FRAC_BITS;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int ITEM_TARGET  = 1800;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 500000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  tts_request_t request = '0;
  logic         done;
  tts_result_t  result;

  tts_request_t pending_requests[$];
  tts_result_t  expected_colors[$];

  // texture image as the block should hold it, updated on accepted writes
  logic [FIELD_W-1:0] image_red[GRID_CELLS];
  logic [FIELD_W-1:0] image_green[GRID_CELLS];
  logic [FIELD_W-1:0] image_blue[GRID_CELLS];
  // cells written by the generated stream so far
  bit                 cell_loaded[GRID_CELLS];

  int error_count;
  int checked_count;
  int write_count;
  int samples_sent;
  int edge_samples;
  int cycle_count;
  int burst_left;
  int gap_left;
  int hot_base[3];

  trilinear_texel_sampler_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int cell_index(int x, int y, int z);
    return (z * TTS_GRID_SIZE + y) * TTS_GRID_SIZE + x;
  endfunction

  function automatic void split_axis(input logic [COORD_W-1:0] c, output int lo,
                                     output int hi, output int frac);
    int v;
    v = c;
    if (v > GRID_TOP) v = GRID_TOP;
    lo = v >> TTS_FRAC_BITS;
    hi = (lo + 1 < TTS_GRID_SIZE) ? lo + 1 : TTS_GRID_SIZE - 1;
    frac = v & (FRAC_ONE - 1);
  endfunction

  function automatic tts_result_t blend_texels(tts_request_t rq);
    int          xi[2], yi[2], zi[2];
    int          fx, fy, fz, addr;
    bit [63:0]   wx[2], wy[2], wz[2];
    bit [63:0]   w, acc_r, acc_g, acc_b;
    tts_result_t res;
    split_axis(rq.sample_x, xi[0], xi[1], fx);
    split_axis(rq.sample_y, yi[0], yi[1], fy);
    split_axis(rq.sample_z, zi[0], zi[1], fz);
    wx[0] = FRAC_ONE - fx; wx[1] = fx;
    wy[0] = FRAC_ONE - fy; wy[1] = fy;
    wz[0] = FRAC_ONE - fz; wz[1] = fz;
    acc_r = '0; acc_g = '0; acc_b = '0;
    for (int c = 0; c < 2; c++)
      for (int b = 0; b < 2; b++)
        for (int a = 0; a < 2; a++) begin
          w = wz[c] * wy[b] * wx[a];
          addr = cell_index(xi[a], yi[b], zi[c]);
          acc_r += w * image_red[addr];
          acc_g += w * image_green[addr];
          acc_b += w * image_blue[addr];
        end
    res.out_red   = OUT_W'(acc_r >> (3 * TTS_FRAC_BITS));
    res.out_green = OUT_W'(acc_g >> (3 * TTS_FRAC_BITS));
    res.out_blue  = OUT_W'(acc_b >> (3 * TTS_FRAC_BITS));
    return res;
  endfunction

  function automatic tts_request_t noise_request();
    tts_request_t rq;
    rq.write_x     = WIDX_W'($urandom);
    rq.write_y     = WIDX_W'($urandom);
    rq.write_z     = WIDX_W'($urandom);
    rq.texel_red   = FIELD_W'($urandom);
    rq.texel_green = FIELD_W'($urandom);
    rq.texel_blue  = FIELD_W'($urandom);
    rq.sample_x    = COORD_W'($urandom);
    rq.sample_y    = COORD_W'($urandom);
    rq.sample_z    = COORD_W'($urandom);
    rq.command     = CMD_WRITE;
    return rq;
  endfunction

  task automatic push_write(int x, int y, int z, logic [FIELD_W-1:0] r,
                            logic [FIELD_W-1:0] g, logic [FIELD_W-1:0] b);
    tts_request_t rq;
    rq = noise_request();
    rq.command     = CMD_WRITE;
    rq.write_x     = WIDX_W'(x);
    rq.write_y     = WIDX_W'(y);
    rq.write_z     = WIDX_W'(z);
    rq.texel_red   = r;
    rq.texel_green = g;
    rq.texel_blue  = b;
    cell_loaded[cell_index(x, y, z)] = 1'b1;
    pending_requests.push_back(rq);
  endtask

  // loads any corner not yet written, then queues the sample itself
  task automatic push_sample(int sx, int sy, int sz);
    int           xi[2], yi[2], zi[2];
    int           f;
    tts_request_t rq;
    split_axis(COORD_W'(sx), xi[0], xi[1], f);
    split_axis(COORD_W'(sy), yi[0], yi[1], f);
    split_axis(COORD_W'(sz), zi[0], zi[1], f);
    for (int c = 0; c < 2; c++)
      for (int b = 0; b < 2; b++)
        for (int a = 0; a < 2; a++)
          if (!cell_loaded[cell_index(xi[a], yi[b], zi[c])])
            push_write(xi[a], yi[b], zi[c], FIELD_W'($urandom), FIELD_W'($urandom),
                       FIELD_W'($urandom));
    // write right ahead of the read now and then
    if ($urandom_range(9) == 0)
      push_write(xi[$urandom_range(1)], yi[$urandom_range(1)], zi[$urandom_range(1)],
                 FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
    if (sx > GRID_TOP || sy > GRID_TOP || sz > GRID_TOP) edge_samples++;
    rq = noise_request();
    rq.command  = CMD_SAMPLE;
    rq.sample_x = COORD_W'(sx);
    rq.sample_y = COORD_W'(sy);
    rq.sample_z = COORD_W'(sz);
    pending_requests.push_back(rq);
  endtask

  function automatic int pick_coord(int base);
    int m, v;
    m = $urandom_range(99);
    if (m < 70) begin
      v = base * FRAC_ONE + $urandom_range(0, 4 * FRAC_ONE - 1);
    end else if (m < 85) begin
      v = $urandom_range(0, COORD_MAX);
    end else begin
      case ($urandom_range(5))
        0: v = 0;
        1: v = FRAC_ONE - 1;
        2: v = GRID_TOP - 1;
        3: v = GRID_TOP;
        4: v = COORD_MAX;
        default: v = GRID_TOP + $urandom_range(1, COORD_MAX - GRID_TOP);
      endcase
    end
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // request driver: bursts of random length, random gaps in between
  always @(posedge clk) begin
    tts_request_t rq;
    bit           take, go;
    if (rst) begin
      start      <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      take = start && !busy;
      if (take) begin
        rq = pending_requests.pop_front();
        if (rq.command == CMD_SAMPLE) begin
          expected_colors.push_back(blend_texels(rq));
          samples_sent++;
        end else begin
          image_red[cell_index(rq.write_x, rq.write_y, rq.write_z)]   = rq.texel_red;
          image_green[cell_index(rq.write_x, rq.write_y, rq.write_z)] = rq.texel_green;
          image_blue[cell_index(rq.write_x, rq.write_y, rq.write_z)]  = rq.texel_blue;
          write_count++;
        end
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      go = start && !take;
      if (!go && gap_left > 0) gap_left--;
      else if (!go && pending_requests.size() != 0) go = 1'b1;
      start <= go;
      if (go) request <= pending_requests[0];
    end
  end

  // result monitor
  always @(posedge clk) begin
    tts_result_t want;
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("tb_top: unexpected result r=%h g=%h b=%h",
                   result.out_red, result.out_green, result.out_blue);
      end else begin
        want = expected_colors.pop_front();
        if (result.out_red !== want.out_red || result.out_green !== want.out_green ||
            result.out_blue !== want.out_blue) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("tb_top: mismatch on sample %0d exp r=%h g=%h b=%h got r=%h g=%h b=%h",
                     checked_count, want.out_red, want.out_green, want.out_blue,
                     result.out_red, result.out_green, result.out_blue);
        end
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d requests and %0d results outstanding",
               cycle_count, pending_requests.size(), expected_colors.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int r, i;
    // origin cell: red at full scale, green zero
    for (i = 0; i < 8; i++)
      push_write(i & 1, (i >> 1) & 1, (i >> 2) & 1, 16'hFFFF, 16'h0000,
                 FIELD_W'(16'h2000 * i + 16'h1FFF));
    push_sample(0, 0, 0);
    push_sample(FRAC_ONE / 2, FRAC_ONE / 4, FRAC_ONE - 1);
    push_sample(FRAC_ONE - 1, FRAC_ONE - 1, FRAC_ONE - 1);
    // far corner cell: green at full scale, red zero
    for (i = 0; i < 8; i++)
      push_write(TTS_GRID_SIZE - 2 + (i & 1), TTS_GRID_SIZE - 2 + ((i >> 1) & 1),
                 TTS_GRID_SIZE - 2 + ((i >> 2) & 1), 16'h0000, 16'hFFFF, FIELD_W'($urandom));
    push_sample(GRID_TOP, GRID_TOP, GRID_TOP);
    push_sample(COORD_MAX, COORD_MAX, COORD_MAX);
    push_sample(GRID_TOP - 1, GRID_TOP - FRAC_ONE, GRID_TOP + 64);

    hot_base[0] = $urandom_range(0, TTS_GRID_SIZE - 1);
    hot_base[1] = $urandom_range(0, TTS_GRID_SIZE - 1);
    hot_base[2] = $urandom_range(0, TTS_GRID_SIZE - 1);
    while (pending_requests.size() < ITEM_TARGET) begin
      if ($urandom_range(59) == 0)
        hot_base[$urandom_range(2)] = $urandom_range(0, TTS_GRID_SIZE - 1);
      r = $urandom_range(99);
      if (r < 12)
        push_write($urandom_range(0, TTS_GRID_SIZE - 1), $urandom_range(0, TTS_GRID_SIZE - 1),
                   $urandom_range(0, TTS_GRID_SIZE - 1), FIELD_W'($urandom),
                   FIELD_W'($urandom), FIELD_W'($urandom));
      else
        push_sample(pick_coord(hot_base[0]), pick_coord(hot_base[1]),
                    pick_coord(hot_base[2]));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_requests.size() != 0 || expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d texel writes, %0d samples sent, %0d checked (%0d clamped)",
             write_count, samples_sent, checked_count, edge_samples);
    $display("tb_top: %0d failures in %0d cycles", error_count, cycle_count);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/tts_pkg.sv
hdl/tts_front.sv
hdl/tts_queue.sv
hdl/tts_back.sv
hdl/trilinear_texel_sampler_top.sv
tb/tb_top.sv
